[rtl/tcch_pkg.sv]
// Shared constants, table and types for the tilt-compensated compass heading block.
// Used by tcch_vec, tcch_rot and tilt_compensated_compass_heading. No dependencies.
package tcch_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;

  localparam int ANG_W  = 32;                 // binary angle, full turn is 2^32
  localparam int MAG_W  = SAMPLE_BITS + 1;    // corrected magnetometer axis
  localparam int ACC_W  = 32;                 // accelerometer axis scaled to 32 bits
  localparam int NAX_W  = ACC_W + 1;          // negated forward acceleration
  localparam int VEC_W  = MAG_W + 35;         // vectoring datapath, holds mxH/myH growth
  localparam int ROT_W  = 34;                 // rotation datapath, Q30 sine/cosine
  localparam int HEAD_W = 13;
  localparam int IN_W   = ((6 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W  = ((HEAD_W + 7) / 8) * 8;

  localparam int FULL_HEAD = 5760;
  localparam int QUARTER   = 1073741824;

  localparam logic [29:0]      GAIN_INV  = 30'd652032874;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  localparam logic [ANG_W-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Side data that rides along with an item through the CORDIC pipelines.
  typedef struct packed {
    logic                    deg;
    logic signed [MAG_W-1:0] mx;
    logic signed [MAG_W-1:0] my;
    logic signed [MAG_W-1:0] mz;
    logic [ANG_W-1:0]        ang;
    logic signed [NAX_W-1:0] nax;
  } tag_t;

endpackage

[rtl/tilt_compensated_compass_heading.sv]
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tcch_pkg, tcch_vec and tcch_rot.
//
// Each request on the in_ stream carries one magnetometer sample and one
// accelerometer sample; each produces exactly one request on the out_ stream
// with the heading in 1/16 degree (0..5759) and a degenerate flag in tuser.
// Hard-iron offsets are written over the APB-style cfg_ port at byte
// addresses 0, 4 and 8, and are meant to change only while the pipe is empty.
// The datapath is a fixed pipeline: input register, roll vectoring CORDIC,
// a two-stage gain-correction multiply, pitch vectoring CORDIC, two parallel
// rotation CORDICs, three product/sum stages, heading vectoring CORDIC, the
// degree scaling multiply and the output register. Each CORDIC takes
// CORDIC_STEPS+1 stages. Throughput is one request per cycle while out_tready
// does not stall the pipe. The whole pipe advances on one enable that is high
// when the output register is empty or being taken, so a stall on out_tready
// holds every stage and in_tready drops with it; nothing is lost or repeated.
// Reset clears all valid bits and the offset registers; there is no clearing
// pass, the block accepts requests right after reset.
module tilt_compensated_compass_heading (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: mag_x, mag_y, mag_z, acc_x, acc_y, acc_z (SAMPLE_BITS each, lowest first)
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tcch_pkg::IN_W-1:0]    in_tdata,
  // out_tdata: heading (13 bits), zero padded; out_tuser: degenerate
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tcch_pkg::OUT_W-1:0]   out_tdata,
  output logic [0:0]                   out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [3:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import tcch_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int MAG_SPLIT = 17;               // low part of the roll magnitude
  localparam int MAG_BITS  = 34;               // roll magnitude stays below 2^34
  localparam int PROD_W    = MAG_SPLIT + 30;
  localparam int SUM_W     = PROD_W + MAG_SPLIT;
  localparam int T_W       = MAG_W + ROT_W;
  localparam int HP_W      = ANG_W + HEAD_W;

  // ---------------- configuration registers ----------------
  logic signed [SB-1:0] off_x_r, off_y_r, off_z_r;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_OFFSET_X: off_x_r <= cfg_pwdata[SB-1:0];
        REG_OFFSET_Y: off_y_r <= cfg_pwdata[SB-1:0];
        REG_OFFSET_Z: off_z_r <= cfg_pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_OFFSET_X: cfg_prdata = 32'(off_x_r);
      REG_OFFSET_Y: cfg_prdata = 32'(off_y_r);
      REG_OFFSET_Z: cfg_prdata = 32'(off_z_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- input stage: offsets, scaling ----------------
  logic signed [SB-1:0]    in_mx, in_my, in_mz, in_ax, in_ay, in_az;
  logic                    s1_v_r;
  logic signed [ACC_W-1:0] s1_ay_r, s1_az_r;
  tag_t                    s1_tag_r;
  logic signed [ACC_W-1:0] s1_ax_nxt, s1_ay_nxt, s1_az_nxt;
  tag_t                    s1_tag_nxt;

  assign in_mx = $signed(in_tdata[0*SB +: SB]);
  assign in_my = $signed(in_tdata[1*SB +: SB]);
  assign in_mz = $signed(in_tdata[2*SB +: SB]);
  assign in_ax = $signed(in_tdata[3*SB +: SB]);
  assign in_ay = $signed(in_tdata[4*SB +: SB]);
  assign in_az = $signed(in_tdata[5*SB +: SB]);

  always_comb begin
    s1_ax_nxt      = $signed({in_ax, {(ACC_W-SB){1'b0}}});
    s1_ay_nxt      = $signed({in_ay, {(ACC_W-SB){1'b0}}});
    s1_az_nxt      = $signed({in_az, {(ACC_W-SB){1'b0}}});
    s1_tag_nxt     = '0;
    s1_tag_nxt.deg = (in_ax == '0) && (in_ay == '0) && (in_az == '0);
    s1_tag_nxt.mx  = MAG_W'(in_mx) - MAG_W'(off_x_r);
    s1_tag_nxt.my  = MAG_W'(in_my) - MAG_W'(off_y_r);
    s1_tag_nxt.mz  = MAG_W'(in_mz) - MAG_W'(off_z_r);
    s1_tag_nxt.nax = -NAX_W'(s1_ax_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ay_r  <= s1_ay_nxt;
      s1_az_r  <= s1_az_nxt;
      s1_tag_r <= s1_tag_nxt;
    end
  end

  // ---------------- roll: atan2(ay, az) and root ----------------
  logic                    rv_v;
  logic [ANG_W-1:0]        rv_ang;
  logic signed [VEC_W-1:0] rv_mag;
  tag_t                    rv_tag;

  tcch_vec u_roll_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_v_r),
    .in_x      (VEC_W'(s1_az_r)),
    .in_y      (VEC_W'(s1_ay_r)),
    .in_tag    (s1_tag_r),
    .out_valid (rv_v),
    .out_ang   (rv_ang),
    .out_mag   (rv_mag),
    .out_tag   (rv_tag)
  );

  // ---------------- gain correction of the root, split multiply ----------------
  logic                  m1_v_r, m2_v_r;
  logic [PROD_W-1:0]     m1_plo_r, m1_phi_r;
  tag_t                  m1_tag_r, m2_tag_r;
  logic [MAG_BITS-1:0]   m2_r_r;
  logic [MAG_BITS-1:0]   rv_mag_u;
  logic [SUM_W-1:0]      m2_sum;
  tag_t                  m1_tag_nxt;

  assign rv_mag_u = rv_mag[MAG_BITS-1:0];
  assign m2_sum   = {m1_phi_r, {MAG_SPLIT{1'b0}}} + SUM_W'(m1_plo_r);

  always_comb begin
    m1_tag_nxt     = rv_tag;
    m1_tag_nxt.ang = rv_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= rv_v;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_plo_r <= rv_mag_u[MAG_SPLIT-1:0] * GAIN_INV;
      m1_phi_r <= rv_mag_u[MAG_BITS-1:MAG_SPLIT] * GAIN_INV;
      m1_tag_r <= m1_tag_nxt;
      m2_r_r   <= m2_sum[SUM_W-1:30];
      m2_tag_r <= m1_tag_r;
    end
  end

  // ---------------- pitch: atan2(-ax, root) ----------------
  logic             pv_v;
  logic [ANG_W-1:0] pv_ang;
  tag_t             pv_tag;

  tcch_vec u_pitch_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m2_v_r),
    .in_x      (VEC_W'($signed({1'b0, m2_r_r}))),
    .in_y      (VEC_W'(m2_tag_r.nax)),
    .in_tag    (m2_tag_r),
    .out_valid (pv_v),
    .out_ang   (pv_ang),
    .out_mag   (),
    .out_tag   (pv_tag)
  );

  // ---------------- sine and cosine of pitch and roll ----------------
  logic                    rp_v;
  logic signed [ROT_W-1:0] cp, sp, cr, sr;
  tag_t                    rp_tag;

  tcch_rot u_pitch_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv_v),
    .in_ang    (pv_ang),
    .in_tag    (pv_tag),
    .out_valid (rp_v),
    .out_cos   (cp),
    .out_sin   (sp),
    .out_tag   (rp_tag)
  );

  // The roll rotation runs in lockstep with the pitch one; its side data is unused.
  tcch_rot u_roll_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv_v),
    .in_ang    (pv_tag.ang),
    .in_tag    ('0),
    .out_valid (),
    .out_cos   (cr),
    .out_sin   (sr),
    .out_tag   ()
  );

  // ---------------- stage A: sin(roll)*sin(pitch), sin(roll)*cos(pitch) ----------------
  logic                      a_v_r;
  logic signed [ROT_W-1:0]   a_srsp_r, a_srcp_r, a_cp_r, a_sp_r, a_cr_r;
  tag_t                      a_tag_r;
  logic signed [2*ROT_W-1:0] a_pa, a_pb;

  assign a_pa = sr * sp;
  assign a_pb = sr * cp;

  // ---------------- stage B: the five field products ----------------
  logic                  b_v_r;
  logic signed [T_W-1:0] b_t1_r, b_t2_r, b_t3_r, b_t4_r, b_t5_r;
  logic                  b_deg_r;

  // ---------------- stage C: mxH and -myH ----------------
  logic                    c_v_r;
  logic signed [VEC_W-1:0] c_mxh_r, c_nmyh_r;
  logic                    c_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= rp_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_srsp_r <= a_pa[ROT_W+29:30];
      a_srcp_r <= a_pb[ROT_W+29:30];
      a_cp_r   <= cp;
      a_sp_r   <= sp;
      a_cr_r   <= cr;
      a_tag_r  <= rp_tag;

      b_t1_r   <= a_tag_r.mx * a_cp_r;
      b_t2_r   <= a_tag_r.mz * a_sp_r;
      b_t3_r   <= a_tag_r.mx * a_srsp_r;
      b_t4_r   <= a_tag_r.my * a_cr_r;
      b_t5_r   <= a_tag_r.mz * a_srcp_r;
      b_deg_r  <= a_tag_r.deg;

      c_mxh_r  <= VEC_W'(b_t1_r) + VEC_W'(b_t2_r);
      c_nmyh_r <= VEC_W'(b_t5_r) - VEC_W'(b_t3_r) - VEC_W'(b_t4_r);
      c_deg_r  <= b_deg_r;
    end
  end

  // ---------------- heading angle: atan2(-myH, mxH) ----------------
  tag_t             f_tag_in;
  logic             fv_v;
  logic [ANG_W-1:0] fv_ang;
  tag_t             fv_tag;

  always_comb begin
    f_tag_in     = '0;
    f_tag_in.deg = c_deg_r;
  end

  tcch_vec u_head_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_x      (c_mxh_r),
    .in_y      (c_nmyh_r),
    .in_tag    (f_tag_in),
    .out_valid (fv_v),
    .out_ang   (fv_ang),
    .out_mag   (),
    .out_tag   (fv_tag)
  );

  // ---------------- scale to 1/16 degree, round, wrap ----------------
  logic              h_v_r;
  logic [HP_W-1:0]   h_p_r;
  logic              h_deg_r;
  logic [HP_W:0]     h_sum;
  logic [HEAD_W:0]   h_round;
  logic [HEAD_W-1:0] head_nxt;
  logic [HEAD_W-1:0] out_head_r;
  logic              out_deg_r;

  assign h_sum   = (HP_W+1)'(h_p_r) + (HP_W+1)'(HALF_TURN);
  assign h_round = h_sum[HP_W:ANG_W];

  always_comb begin
    if (h_deg_r || h_round >= (HEAD_W+1)'(FULL_HEAD)) begin
      head_nxt = '0;
    end else begin
      head_nxt = h_round[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      h_v_r       <= fv_v;
      out_valid_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_p_r      <= fv_ang * HEAD_W'(FULL_HEAD);
      h_deg_r    <= fv_tag.deg;
      out_head_r <= head_nxt;
      out_deg_r  <= h_deg_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_head_r);
  assign out_tuser  = out_deg_r;

endmodule

[rtl/tcch_vec.sv]
// Pipelined vectoring CORDIC: angle and raw magnitude of (x, y), one step per stage.
// Depends on tcch_pkg.
module tcch_vec (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [tcch_pkg::VEC_W-1:0]  in_x,
  input  logic signed [tcch_pkg::VEC_W-1:0]  in_y,
  input  tcch_pkg::tag_t                     in_tag,
  output logic                               out_valid,
  output logic [tcch_pkg::ANG_W-1:0]         out_ang,
  output logic signed [tcch_pkg::VEC_W-1:0]  out_mag,
  output tcch_pkg::tag_t                     out_tag
);
  import tcch_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [VEC_W-1:0] x_r [0:N];
  logic signed [VEC_W-1:0] y_r [0:N];
  logic [ANG_W-1:0]        z_r [0:N];
  logic                    zero_r [0:N];
  logic                    v_r [0:N];
  tag_t                    tag_r [0:N];

  logic signed [VEC_W-1:0] x_nxt [0:N];
  logic signed [VEC_W-1:0] y_nxt [0:N];
  logic [ANG_W-1:0]        z_nxt [0:N];
  logic                    zero_nxt [0:N];
  logic                    v_nxt [0:N];
  tag_t                    tag_nxt [0:N];

  always_comb begin
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    // Entry: a vector in the left half plane is turned by a half turn first.
    zero_nxt[0] = (in_x == '0) && (in_y == '0);
    v_nxt[0]    = in_valid;
    tag_nxt[0]  = in_tag;
    if (in_x < 0) begin
      x_nxt[0] = -in_x;
      y_nxt[0] = -in_y;
      z_nxt[0] = HALF_TURN;
    end else begin
      x_nxt[0] = in_x;
      y_nxt[0] = in_y;
      z_nxt[0] = '0;
    end
    for (int i = 0; i < N; i++) begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      zero_nxt[i+1] = zero_r[i];
      v_nxt[i+1]    = v_r[i];
      tag_nxt[i+1]  = tag_r[i];
      if (y_r[i] > 0) begin
        x_nxt[i+1] = x_r[i] + ys;
        y_nxt[i+1] = y_r[i] - xs;
        z_nxt[i+1] = z_r[i] + ATAN_TAB[i];
      end else begin
        x_nxt[i+1] = x_r[i] - ys;
        y_nxt[i+1] = y_r[i] + xs;
        z_nxt[i+1] = z_r[i] - ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
      tag_r  <= tag_nxt;
    end
  end

  // A zero vector has no direction; it reports angle zero.
  assign out_valid = v_r[N];
  assign out_ang   = zero_r[N] ? '0 : z_r[N];
  assign out_mag   = x_r[N];
  assign out_tag   = tag_r[N];

endmodule

[rtl/tcch_rot.sv]
// Pipelined rotation CORDIC: Q30 cosine and sine of a binary angle, one step per stage.
// Depends on tcch_pkg.
module tcch_rot (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [tcch_pkg::ANG_W-1:0]         in_ang,
  input  tcch_pkg::tag_t                     in_tag,
  output logic                               out_valid,
  output logic signed [tcch_pkg::ROT_W-1:0]  out_cos,
  output logic signed [tcch_pkg::ROT_W-1:0]  out_sin,
  output tcch_pkg::tag_t                     out_tag
);
  import tcch_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [ROT_W-1:0] x_r [0:N];
  logic signed [ROT_W-1:0] y_r [0:N];
  logic signed [ROT_W-1:0] z_r [0:N];
  logic                    flip_r [0:N];
  logic                    v_r [0:N];
  tag_t                    tag_r [0:N];

  logic signed [ROT_W-1:0] x_nxt [0:N];
  logic signed [ROT_W-1:0] y_nxt [0:N];
  logic signed [ROT_W-1:0] z_nxt [0:N];
  logic                    flip_nxt [0:N];
  logic                    v_nxt [0:N];
  tag_t                    tag_nxt [0:N];

  always_comb begin
    logic signed [ANG_W-1:0] sa;
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    // Entry: angles beyond a quarter turn are folded by a half turn and the
    // result is negated at the end.
    sa          = $signed(in_ang);
    v_nxt[0]    = in_valid;
    tag_nxt[0]  = in_tag;
    x_nxt[0]    = ROT_W'(GAIN_INV);
    y_nxt[0]    = '0;
    if (sa > QUARTER || sa < -QUARTER) begin
      z_nxt[0]    = ROT_W'($signed(in_ang + HALF_TURN));
      flip_nxt[0] = 1'b1;
    end else begin
      z_nxt[0]    = ROT_W'(sa);
      flip_nxt[0] = 1'b0;
    end
    for (int i = 0; i < N; i++) begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      flip_nxt[i+1] = flip_r[i];
      v_nxt[i+1]    = v_r[i];
      tag_nxt[i+1]  = tag_r[i];
      if (z_r[i] >= 0) begin
        x_nxt[i+1] = x_r[i] - ys;
        y_nxt[i+1] = y_r[i] + xs;
        z_nxt[i+1] = z_r[i] - $signed(ROT_W'(ATAN_TAB[i]));
      end else begin
        x_nxt[i+1] = x_r[i] + ys;
        y_nxt[i+1] = y_r[i] - xs;
        z_nxt[i+1] = z_r[i] + $signed(ROT_W'(ATAN_TAB[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      flip_r <= flip_nxt;
      tag_r  <= tag_nxt;
    end
  end

  assign out_valid = v_r[N];
  assign out_cos   = flip_r[N] ? -x_r[N] : x_r[N];
  assign out_sin   = flip_r[N] ? -y_r[N] : y_r[N];
  assign out_tag   = tag_r[N];

endmodule

[test/tb_tilt_compensated_compass_heading.sv]
// Self-checking testbench for tilt_compensated_compass_heading.
// Depends on tcch_pkg and the RTL of the block. An integer CORDIC predictor
// computes each expected heading, and a scoreboard checks the out_ stream.
module tb_tilt_compensated_compass_heading;
  import tcch_pkg::*;

  // Run limit in cycles. It covers about 1400 requests at heavy stall, with
  // wide margin.
  localparam int LIMIT = 400000;
  localparam int DRAIN = 4 * (CORDIC_STEPS + 1) + 24;

  typedef struct packed {
    logic signed [15:0] acc_z;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] mag_z;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_x;
  } sample_t;

  typedef struct {
    logic [HEAD_W-1:0] heading;
    logic              degenerate;
  } heading_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;    // mag_x, mag_y, mag_z, acc_x, acc_y, acc_z
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;  // heading, zero padded
  logic [0:0] out_tuser;        // degenerate
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  tilt_compensated_compass_heading uut (.*);

  // Offsets as the block should currently hold them.
  logic signed [15:0] hard_iron [3];

  sample_t  pending_q [$];
  heading_t heading_q [$];

  int send_idle, recv_idle;
  bit hold_send;
  logic in_taken;
  int cycles, mismatches, requests, results, degenerate_seen;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------- predictor

  // Vectoring CORDIC: angle of (x, y) as a binary angle, raw magnitude out.
  function automatic logic [31:0] vector_angle(input longint x0, input longint y0,
                                               output longint mag);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = x0;
    y = y0;
    z = '0;
    mag = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint to_signed_angle(input logic [31:0] a);
    return longint'(signed'(a));
  endfunction

  // Rotation CORDIC: Q30 cosine and sine of a binary angle. Angles beyond a
  // quarter turn are folded by a half turn and the result negated.
  function automatic void sin_cos(input logic [31:0] th, output longint c,
                                  output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = longint'(GAIN_INV);
    y = 0;
    z = to_signed_angle(th);
    flip = 0;
    if (z > QUARTER || z < -QUARTER) begin
      z = to_signed_angle(th + HALF_TURN);
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic heading_t predict_heading(input sample_t t);
    heading_t h;
    longint mx, my, mz, ax, ay, az, mag, r, unused, cr, sr, cp, sp, srsp, srcp;
    longint mxh, myh;
    longint unsigned wide;
    logic [31:0] roll, pitch, ang;
    h.degenerate = 1'b0;
    h.heading = '0;
    if (t.acc_x == 0 && t.acc_y == 0 && t.acc_z == 0) begin
      h.degenerate = 1'b1;
      return h;
    end
    mx = longint'(t.mag_x) - longint'(hard_iron[0]);
    my = longint'(t.mag_y) - longint'(hard_iron[1]);
    mz = longint'(t.mag_z) - longint'(hard_iron[2]);
    ax = longint'(t.acc_x) <<< (32 - SAMPLE_BITS);
    ay = longint'(t.acc_y) <<< (32 - SAMPLE_BITS);
    az = longint'(t.acc_z) <<< (32 - SAMPLE_BITS);
    roll = vector_angle(az, ay, mag);
    wide = (longint'(unsigned'(mag)) * longint'(GAIN_INV)) >> 30;
    r = longint'(wide);
    pitch = vector_angle(r, -ax, unused);
    sin_cos(roll, cr, sr);
    sin_cos(pitch, cp, sp);
    srsp = (sr * sp) >>> 30;
    srcp = (sr * cp) >>> 30;
    mxh = mx * cp + mz * sp;
    myh = mx * srsp + my * cr - mz * srcp;
    ang = vector_angle(mxh, -myh, unused);
    wide = (longint'({32'd0, ang}) * FULL_HEAD + longint'({32'd0, HALF_TURN})) >> 32;
    // A heading that rounds up to a full turn reads as north.
    h.heading = (wide >= FULL_HEAD) ? '0 : HEAD_W'(wide);
    return h;
  endfunction

  // ---------------------------------------------------------------- driver

  // A request stays on the bus until it is taken; a new one is offered only
  // when the bus is free, unless the sender is idling or held back.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          in_tdata <= pending_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    heading_t want;
    in_taken <= in_tvalid && in_tready;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, heading_q.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      heading_q.push_back(predict_heading(sample_t'(in_tdata)));
      requests <= requests + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results <= results + 1;
      if (heading_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("Unexpected result heading=%0d degenerate=%0d",
                   out_tdata[HEAD_W-1:0], out_tuser);
      end else begin
        want = heading_q.pop_front();
        if (want.degenerate) degenerate_seen <= degenerate_seen + 1;
        if (out_tdata[HEAD_W-1:0] !== want.heading || out_tuser[0] !== want.degenerate) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch at result %0d: heading exp %0d got %0d, degenerate exp %0d got %0d",
                     results, want.heading, out_tdata[HEAD_W-1:0], want.degenerate, out_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_offset(input int idx, input logic signed [15:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 4'(4 * idx);
    cfg_pwdata <= {{16{value[15]}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    // Only the three offset registers exist; other addresses are ignored.
    if (idx <= int'(REG_OFFSET_Z)) hard_iron[idx] = value;
  endtask

  // Mostly random words, with a good share of the extremes and of values near zero.
  function automatic logic signed [15:0] axis_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t t;
    int pick;
    t.mag_x = axis_value();
    t.mag_y = axis_value();
    t.mag_z = axis_value();
    t.acc_x = axis_value();
    t.acc_y = axis_value();
    t.acc_z = axis_value();
    pick = $urandom_range(39);
    if (pick == 0) begin
      // zero accelerometer vector
      t.acc_x = '0; t.acc_y = '0; t.acc_z = '0;
    end else if (pick == 1) begin
      // no roll vector, only forward acceleration
      t.acc_y = '0; t.acc_z = '0;
    end else if (pick == 2) begin
      // field cancelled exactly by the offsets
      t.mag_x = hard_iron[0]; t.mag_y = hard_iron[1]; t.mag_z = hard_iron[2];
    end
    return t;
  endfunction

  function automatic sample_t make_sample(input int mx, input int my, input int mz,
                                          input int ax, input int ay, input int az);
    sample_t t;
    t.mag_x = 16'(mx); t.mag_y = 16'(my); t.mag_z = 16'(mz);
    t.acc_x = 16'(ax); t.acc_y = 16'(ay); t.acc_z = 16'(az);
    return t;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || heading_q.size() != 0) @(posedge clk);
    // Let the last result clear the output register before anything changes.
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] offs [3];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_taken = 1'b0;
    hold_send = 0;
    cycles = 0;
    mismatches = 0;
    requests = 0;
    results = 0;
    degenerate_seen = 0;
    hard_iron[0] = '0; hard_iron[1] = '0; hard_iron[2] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Six offset settings. The first two run with a busy sender and a
    // slow receiver, the next two the other way round, the last two flat out.
    for (int phase = 0; phase < 6; phase++) begin
      send_idle = (phase < 2) ? 17 : (phase < 4) ? 84 : 0;
      recv_idle = (phase < 2) ? 84 : (phase < 4) ? 17 : 0;
      case (phase)
        0: begin offs[0] = 0; offs[1] = 0; offs[2] = 0; end
        1: begin offs[0] = 16'sh7fff; offs[1] = 16'sh8000; offs[2] = 16'sh7fff; end
        2: begin offs[0] = 16'sh8000; offs[1] = 16'sh7fff; offs[2] = 16'sh8000; end
        3: begin offs[0] = 120; offs[1] = -75; offs[2] = 300; end
        default: begin offs[0] = 16'($urandom); offs[1] = 16'($urandom); offs[2] = 16'($urandom); end
      endcase
      for (int r = 0; r < 3; r++) write_offset(r, offs[r]);
      // An address past the last register must leave the offsets alone.
      if (phase == 1) write_offset(3, 16'sh1234);

      if (phase == 0) begin
        pending_q.push_back(make_sample(100, 200, 300, 0, 0, 0));
        pending_q.push_back(make_sample(-32768, -32768, -32768, 0, 0, 0));
        pending_q.push_back(make_sample(1000, 500, -200, 16384, 0, 0));
        pending_q.push_back(make_sample(1000, 500, -200, -16384, 0, 0));
        pending_q.push_back(make_sample(-32768, 32767, 0, 32767, 0, 0));
        pending_q.push_back(make_sample(0, 0, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(0, 0, 0, 3000, -2000, 9000));
        pending_q.push_back(make_sample(20000, 1, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(20000, -1, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(20000, 0, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(0, 20000, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(-20000, 0, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(0, -20000, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(-20000, -1, 0, 0, 0, 16384));
        pending_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        pending_q.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_q.push_back(make_sample(32767, -32768, 32767, -32768, 32767, -32768));
        pending_q.push_back(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
        pending_q.push_back(make_sample(5000, 3000, 12000, 0, 16384, 0));
        pending_q.push_back(make_sample(5000, 3000, 12000, 0, -16384, 0));
        pending_q.push_back(make_sample(5000, 3000, 12000, 0, 0, -16384));
        pending_q.push_back(make_sample(5000, 3000, 12000, 8000, 8000, 8000));
        pending_q.push_back(make_sample(-7, 3, 1, -1, 1, -1));
      end
      for (int n = 0; n < 230; n++) pending_q.push_back(random_sample());

      if (phase == 3) begin
        // Hold the sender back once until the pipe has emptied completely.
        while (pending_q.size() > 100) @(posedge clk);
        hold_send = 1;
        while (in_tvalid || heading_q.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      drain();
    end

    $display("Covered %0d requests and %0d results over six offset settings, %0d degenerate.",
             requests, results, degenerate_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[tilt_compensated_compass_heading.f]
rtl/tcch_pkg.sv
rtl/tcch_vec.sv
rtl/tcch_rot.sv
rtl/tilt_compensated_compass_heading.sv
test/tb_tilt_compensated_compass_heading.sv
